/* rtl/symmetric_bit_adjacency_matrix_assert.svh */
// Assertion macros used by sbam_seq. Each macro expects clk and rst_n in scope.
`ifndef SYMMETRIC_BIT_ADJACENCY_MATRIX_ASSERT_SVH
`define SYMMETRIC_BIT_ADJACENCY_MATRIX_ASSERT_SVH

// Same-cycle implication.
`define SBAM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbam assertion failed");

// Next-cycle implication.
`define SBAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbam assertion failed");

`endif

/* rtl/sbam_pkg.sv */
`timescale 1ns / 1ps
package sbam_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int ROW_W     = 64;
    localparam int CNT_W     = 7;
    localparam int BOUND_W   = 7;
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(64);

    typedef enum logic [1:0] {
        FUNC_JOIN    = 2'd0,
        FUNC_DISJOIN = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_ENUM    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        func_t             func;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic              status;
        logic              connected;
        logic              edge_valid;
        logic [NODE_W-1:0] col_node;
        logic [NODE_W-1:0] row_node;
        logic              last;
    } rsp_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        logic [ROW_W-1:0]  data;
    } store_wr_t;

endpackage

/* rtl/symmetric_bit_adjacency_matrix.sv */
`timescale 1ns / 1ps
// Channel   Direction  Payload       Handshake
// in        input      req_t         in_valid / in_ready
// out       output     rsp_t         out_valid / out_ready
// cfg       input      node_count    cfg_valid / cfg_ready (always ready)
//
// Join, disjoin and query read the two rows one after the other through the read port of
// the row store; join and disjoin write each row back in the state that receives its read data.
// Out-of-bounds requests skip the row reads and go straight to the response.
// Enumerate reads the row and emits its edges lowest column first.
// Reset and every node_count write clear the store at once through per-row valid flags.
// A stalled output holds the sequencer; one new request may be taken while a result waits.
module symmetric_bit_adjacency_matrix
    import sbam_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rsp_t             out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    logic [BOUND_W-1:0] bound_reg, bound_next;
    logic [CNT_W:0]     rounded;
    logic               cfg_write;
    store_wr_t          wr;
    logic [NODE_W-1:0]  rd_addr;
    logic [ROW_W-1:0]   rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Round up to a multiple of eight, saturate at the store depth.
    assign rounded    = ({1'b0, cfg_data} + (CNT_W+1)'(7)) & ~(CNT_W+1)'(7);
    assign bound_next = (rounded > (CNT_W+1)'(MAX_NODES)) ? BOUND_W'(MAX_NODES) :
                        rounded[BOUND_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= BOUND_W'(NODE_COUNT_RESET);
        end
        else if (cfg_write)
        begin
            bound_reg <= bound_next;
        end
    end

    sbam_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (cfg_write),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    sbam_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .bound     (bound_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

endmodule

/* rtl/sbam_store.sv */
`timescale 1ns / 1ps
module sbam_store
    import sbam_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear_all,
    input  store_wr_t         wr,
    input  logic [NODE_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data
);

    logic [ROW_W-1:0]     mem [MAX_NODES];
    logic [MAX_NODES-1:0] row_valid_reg;
    logic [MAX_NODES-1:0] row_valid_next;
    logic [ROW_W-1:0]     rd_data_reg;
    logic                 rd_valid_reg;

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (clear_all)
        begin
            row_valid_next = '0;
        end
        else if (wr.en)
        begin
            row_valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= row_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // An unwritten row reads as zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* rtl/sbam_lsb.sv */
`timescale 1ns / 1ps
module sbam_lsb
    import sbam_pkg::*;
(
    input  logic [ROW_W-1:0]  vec,
    output logic [NODE_W-1:0] idx,
    output logic [ROW_W-1:0]  rest,
    output logic              rest_zero
);

    logic [ROW_W-1:0] onehot;

    // Isolate the lowest set bit.
    assign onehot = vec & (~vec + ROW_W'(1));

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | NODE_W'(i);
            end
        end
    end

    assign rest      = vec & ~onehot;
    assign rest_zero = (rest == '0);

endmodule

/* rtl/sbam_seq.sv */
`timescale 1ns / 1ps
`include "symmetric_bit_adjacency_matrix_assert.svh"
module sbam_seq
    import sbam_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [BOUND_W-1:0] bound,
    input  logic               in_valid,
    output logic               in_ready,
    input  req_t               in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rsp_t               out_data,
    output store_wr_t          wr,
    output logic [NODE_W-1:0]  rd_addr,
    input  logic [ROW_W-1:0]   rd_data
);

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic [NODE_W-1:0] a_reg, a_next;
    logic [NODE_W-1:0] b_reg, b_next;
    logic              conn_reg, conn_next;
    logic [ROW_W-1:0]  scan_reg, scan_next;
    rsp_t              res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg;

    logic              out_load;
    rsp_t              out_load_data;
    logic              slot_free;
    logic              oob_in;
    logic [ROW_W-1:0]  masked_row;
    logic [NODE_W-1:0] lsb_idx;
    logic [ROW_W-1:0]  lsb_rest;
    logic              lsb_rest_zero;

    sbam_lsb u_lsb (
        .vec       (scan_reg),
        .idx       (lsb_idx),
        .rest      (lsb_rest),
        .rest_zero (lsb_rest_zero)
    );

    assign slot_free  = !out_valid_reg || out_ready;
    assign oob_in     = (in_data.func == FUNC_ENUM) ?
                        ({1'b0, in_data.node_b} >= bound) :
                        (({1'b0, in_data.node_a} >= bound) ||
                         ({1'b0, in_data.node_b} >= bound));
    // Keep columns 0..row only.
    assign masked_row = rd_data & ({ROW_W{1'b1}} >> (NODE_W'(ROW_W - 1) - b_reg));

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        conn_next     = conn_reg;
        scan_next     = scan_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        rd_addr       = a_reg;
        wr            = '0;
        out_load      = 1'b0;
        out_load_data = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = (in_data.func == FUNC_ENUM) ? in_data.node_b : in_data.node_a;
                if (in_valid)
                begin
                    func_next = in_data.func;
                    a_next    = in_data.node_a;
                    b_next    = in_data.node_b;
                    conn_next = 1'b0;
                    if (oob_in)
                    begin
                        res_next   = '{status: 1'b1, connected: 1'b0, edge_valid: 1'b0,
                                       col_node: '0, row_node: '0, last: 1'b1};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_READ_A;
                    end
                end
            end

            S_READ_A:
            begin
                rd_addr = b_reg;
                case (func_reg)
                    FUNC_ENUM:
                    begin
                        if (masked_row == '0)
                        begin
                            res_next   = '{status: 1'b0, connected: 1'b0, edge_valid: 1'b0,
                                           col_node: '0, row_node: b_reg, last: 1'b1};
                            state_next = S_RESP;
                        end
                        else
                        begin
                            scan_next  = masked_row;
                            state_next = S_SCAN;
                        end
                    end
                    FUNC_QUERY:
                    begin
                        conn_next  = rd_data[b_reg];
                        state_next = S_READ_B;
                    end
                    default:
                    begin
                        wr.en      = 1'b1;
                        wr.addr    = a_reg;
                        wr.data    = (func_reg == FUNC_JOIN) ?
                                     (rd_data | (ROW_W'(1) << b_reg)) :
                                     (rd_data & ~(ROW_W'(1) << b_reg));
                        state_next = S_READ_B;
                    end
                endcase
            end

            S_READ_B:
            begin
                // When a equals b the read misses the write above, but the
                // second write then stores the same row.
                res_next = '{status: 1'b0, connected: 1'b0, edge_valid: 1'b0,
                             col_node: '0, row_node: '0, last: 1'b1};
                if (func_reg == FUNC_QUERY)
                begin
                    res_next.connected = conn_reg | rd_data[a_reg];
                end
                else
                begin
                    wr.en   = 1'b1;
                    wr.addr = b_reg;
                    wr.data = (func_reg == FUNC_JOIN) ?
                              (rd_data | (ROW_W'(1) << a_reg)) :
                              (rd_data & ~(ROW_W'(1) << a_reg));
                end
                state_next = S_RESP;
            end

            S_SCAN:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_load_data = '{status: 1'b0, connected: 1'b0, edge_valid: 1'b1,
                                      col_node: lsb_idx, row_node: b_reg,
                                      last: lsb_rest_zero};
                    scan_next     = lsb_rest;
                    if (lsb_rest_zero)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        conn_reg <= conn_next;
        scan_reg <= scan_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            out_data_reg <= out_load_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SBAM_ASSERT_NOW(a_scan_nonempty, state_reg == S_SCAN, scan_reg != '0)
    `SBAM_ASSERT_NOW(a_write_no_query, wr.en,
                     (state_reg == S_READ_A || state_reg == S_READ_B) &&
                     (func_reg == FUNC_JOIN || func_reg == FUNC_DISJOIN))
    `SBAM_ASSERT_NOW(a_edge_below_row, out_valid_reg && out_data_reg.edge_valid,
                     out_data_reg.col_node <= out_data_reg.row_node)
    `SBAM_ASSERT_NOW(a_error_is_last, out_valid_reg && out_data_reg.status,
                     out_data_reg.last && !out_data_reg.edge_valid)

endmodule

/* dv/symmetric_bit_adjacency_matrix_test.sv */
`timescale 1ns / 1ps
module symmetric_bit_adjacency_matrix_test;
    import sbam_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    req_t             in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    rsp_t             out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;

    symmetric_bit_adjacency_matrix DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Mirror of the graph store and the node count register
    logic [ROW_W-1:0] adj_rows [MAX_NODES];
    int               node_count_m;

    req_t pending_req[$];
    rsp_t expected_rsp[$];

    bit no_idle;
    int in_gap;
    int out_stall;
    int fail_count;
    int n_requests;
    int n_results;
    int n_edges;
    int n_cfg_writes;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic int node_limit();
        int lim;
        lim = (node_count_m + 7) & ~7;
        return (lim > MAX_NODES) ? MAX_NODES : lim;
    endfunction

    task automatic clear_rows();
        for (int r = 0; r < MAX_NODES; r++)
            adj_rows[r] = '0;
    endtask

    function automatic req_t make_req(func_t f, int a, int b);
        req_t r;
        r.func   = f;
        r.node_a = NODE_W'(a);
        r.node_b = NODE_W'(b);
        return r;
    endfunction

    function automatic rsp_t make_rsp(bit st, bit conn, bit ev, int col, int row, bit lst);
        rsp_t r;
        r.status     = st;
        r.connected  = conn;
        r.edge_valid = ev;
        r.col_node   = NODE_W'(col);
        r.row_node   = NODE_W'(row);
        r.last       = lst;
        return r;
    endfunction

    // Update the mirror and queue every result that one request causes
    function automatic void predict_request(req_t r);
        int   a;
        int   b;
        int   lim;
        int   hits;
        rsp_t tail;
        a   = r.node_a;
        b   = r.node_b;
        lim = node_limit();
        if (r.func == FUNC_ENUM)
        begin
            if (b >= lim)
            begin
                expected_rsp.push_back(make_rsp(1, 0, 0, 0, 0, 1));
                return;
            end
            hits = 0;
            for (int c = 0; c <= b; c++)
            begin
                if (adj_rows[b][c])
                begin
                    expected_rsp.push_back(make_rsp(0, 0, 1, c, b, 0));
                    hits++;
                end
            end
            if (hits == 0)
                expected_rsp.push_back(make_rsp(0, 0, 0, 0, b, 1));
            else
            begin
                tail      = expected_rsp.pop_back();
                tail.last = 1'b1;
                expected_rsp.push_back(tail);
            end
            return;
        end
        if (a >= lim || b >= lim)
        begin
            expected_rsp.push_back(make_rsp(1, 0, 0, 0, 0, 1));
            return;
        end
        case (r.func)
            FUNC_JOIN:
            begin
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
                expected_rsp.push_back(make_rsp(0, 0, 0, 0, 0, 1));
            end
            FUNC_DISJOIN:
            begin
                adj_rows[a][b] = 1'b0;
                adj_rows[b][a] = 1'b0;
                expected_rsp.push_back(make_rsp(0, 0, 0, 0, 0, 1));
            end
            default:
                expected_rsp.push_back(make_rsp(0, adj_rows[a][b] | adj_rows[b][a], 0, 0, 0, 1));
        endcase
    endfunction

    // Mostly in-bounds nodes, often from a small hot set so rows fill up
    function automatic int pick_node(int lim);
        int k;
        k = $urandom_range(0, 19);
        if (lim == 0 || k == 0)
            return $urandom_range(0, 63);
        if (k < 7)
            return $urandom_range(0, ((lim < 8) ? lim : 8) - 1);
        return $urandom_range(0, lim - 1);
    endfunction

    // Driver: present queued requests with a random gap before each
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_request(in_data);
                n_requests++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_req.size() == 0)
                    in_valid <= 1'b0;
                else if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_data  <= pending_req.pop_front();
                    in_valid <= 1'b1;
                    in_gap   <= idle_draw();
                end
            end
        end
    end

    // Monitor: check each accepted result, then stall for a random count
    always @(posedge clk)
    begin
        rsp_t want;
        int   stall;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            stall = out_stall;
            if (out_valid && out_ready)
            begin
                n_results++;
                if (out_data.edge_valid)
                    n_edges++;
                if (expected_rsp.size() == 0)
                begin
                    $error("unexpected result %h with nothing pending", out_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.connected !== want.connected)
                    begin
                        $error("connected: expected %0d, got %0d",
                               want.connected, out_data.connected);
                        fail_count++;
                    end
                    if (out_data.edge_valid !== want.edge_valid)
                    begin
                        $error("edge_valid: expected %0d, got %0d",
                               want.edge_valid, out_data.edge_valid);
                        fail_count++;
                    end
                    if (out_data.col_node !== want.col_node)
                    begin
                        $error("col_node: expected %0d, got %0d",
                               want.col_node, out_data.col_node);
                        fail_count++;
                    end
                    if (out_data.row_node !== want.row_node)
                    begin
                        $error("row_node: expected %0d, got %0d",
                               want.row_node, out_data.row_node);
                        fail_count++;
                    end
                    if (out_data.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, out_data.last);
                        fail_count++;
                    end
                end
                stall = idle_draw();
            end
            else if (out_valid && stall > 0)
                stall--;
            out_ready <= (stall == 0);
            out_stall = stall;
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_req.size() != 0 || in_valid || expected_rsp.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        node_count_m = value;
        clear_rows();
        n_cfg_writes++;
    endtask

    initial
    begin
        int   phase_count [8];
        int   lim;
        int   k;
        func_t f;
        phase_count  = '{64, -1, 8, -1, 100, -1, 1, -1};
        node_count_m = NODE_COUNT_RESET;
        clear_rows();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset node count: extremes, self loops, empty row, absent edge
        pending_req.push_back(make_req(FUNC_JOIN, 0, 63));
        pending_req.push_back(make_req(FUNC_JOIN, 0, 0));
        pending_req.push_back(make_req(FUNC_JOIN, 63, 63));
        pending_req.push_back(make_req(FUNC_JOIN, 5, 3));
        pending_req.push_back(make_req(FUNC_QUERY, 63, 0));
        pending_req.push_back(make_req(FUNC_QUERY, 1, 2));
        pending_req.push_back(make_req(FUNC_ENUM, 0, 63));
        pending_req.push_back(make_req(FUNC_ENUM, 0, 0));
        pending_req.push_back(make_req(FUNC_ENUM, 0, 1));
        pending_req.push_back(make_req(FUNC_ENUM, 0, 5));
        pending_req.push_back(make_req(FUNC_DISJOIN, 63, 0));
        pending_req.push_back(make_req(FUNC_QUERY, 0, 63));
        pending_req.push_back(make_req(FUNC_DISJOIN, 2, 7));
        wait_drained();

        // Zero nodes: everything is out of bounds
        write_node_count(0);
        pending_req.push_back(make_req(FUNC_QUERY, 0, 0));
        pending_req.push_back(make_req(FUNC_ENUM, 0, 0));
        pending_req.push_back(make_req(FUNC_JOIN, 0, 0));
        wait_drained();

        // Count above the limit saturates the bound
        write_node_count(127);
        pending_req.push_back(make_req(FUNC_JOIN, 63, 62));
        pending_req.push_back(make_req(FUNC_ENUM, 0, 63));
        pending_req.push_back(make_req(FUNC_ENUM, 0, 62));
        wait_drained();

        // One node rounds up to a bound of eight
        write_node_count(1);
        pending_req.push_back(make_req(FUNC_JOIN, 7, 7));
        pending_req.push_back(make_req(FUNC_JOIN, 8, 0));
        pending_req.push_back(make_req(FUNC_JOIN, 0, 8));
        pending_req.push_back(make_req(FUNC_ENUM, 63, 8));
        pending_req.push_back(make_req(FUNC_ENUM, 0, 7));
        pending_req.push_back(make_req(FUNC_QUERY, 7, 7));
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            write_node_count((phase_count[p] < 0) ? CNT_W'($urandom_range(1, 64))
                                                  : CNT_W'(phase_count[p]));
            no_idle = (p == 3 || p == 6);
            lim = node_limit();
            for (int i = 0; i < 45; i++)
            begin
                k = $urandom_range(0, 99);
                if (k < 40)
                    f = FUNC_JOIN;
                else if (k < 55)
                    f = FUNC_DISJOIN;
                else if (k < 75)
                    f = FUNC_QUERY;
                else
                    f = FUNC_ENUM;
                pending_req.push_back(make_req(f, pick_node(lim), pick_node(lim)));
            end
            wait_drained();
        end

        $display("Ran %0d requests through %0d node_count settings;", n_requests, n_cfg_writes);
        $display("checked %0d results, %0d of them enumerated edges.", n_results, n_edges);
        if (fail_count == 0)
            $display("symmetric_bit_adjacency_matrix_test: clean");
        else
            $display("symmetric_bit_adjacency_matrix_test: errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("symmetric_bit_adjacency_matrix_test: errors");
        $finish;
    end

endmodule
